>>> rtl/apsr_pkg.sv
// Shared types, constants and helpers for the ATA PIO LBA28 sector reader.
// Used by apsr_ctrl, apsr_emit and the top level; depends on nothing.
package apsr_pkg;

  localparam int unsigned SectorWords = 256;
  localparam int unsigned WordCntW    = $clog2(SectorWords + 1);
  localparam int unsigned PollW       = 20;
  localparam int unsigned LbaW        = 28;
  localparam int unsigned DataW       = 16;
  localparam int unsigned BeatIdxW    = 3;

  localparam logic [PollW-1:0] PollLimitReset = 20'd100000;

  // Task-file register offsets.
  localparam logic [2:0] RegData   = 3'd0;
  localparam logic [2:0] RegSecCnt = 3'd2;
  localparam logic [2:0] RegLbaLo  = 3'd3;
  localparam logic [2:0] RegLbaMid = 3'd4;
  localparam logic [2:0] RegLbaHi  = 3'd5;
  localparam logic [2:0] RegDrive  = 3'd6;
  localparam logic [2:0] RegStatus = 3'd7;

  localparam logic [7:0] DriveSelLba = 8'hE0;
  localparam logic [7:0] CmdReadSect = 8'h20;
  localparam logic [7:0] StatFloat   = 8'hFF;

  typedef enum logic [1:0] {
    CmdProbe = 2'd0,
    CmdRead  = 2'd1,
    CmdData  = 2'd2,
    CmdNone  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KindWrite = 2'd0,
    KindRead  = 2'd1,
    KindWord  = 2'd2,
    KindDone  = 2'd3
  } kind_e;

  // One burst is the full list of result beats caused by one input beat.
  typedef enum logic [2:0] {
    BurstProbe    = 3'd0,
    BurstPoll     = 3'd1,
    BurstDataRd   = 3'd2,
    BurstDone     = 3'd3,
    BurstCmd      = 3'd4,
    BurstWordRd   = 3'd5,
    BurstWordDone = 3'd6,
    BurstNone     = 3'd7
  } burst_e;

  typedef struct packed {
    burst_e           burst;
    logic [LbaW-1:0]  lba;
    logic [DataW-1:0] word;
    logic             success;
    logic             present;
  } apsr_desc_t;

  typedef struct packed {
    kind_e      kind;
    logic [2:0] port;
    logic [7:0] wval;
    logic [15:0] word;
    logic       success;
  } apsr_beat_t;

  function automatic logic [BeatIdxW-1:0] burst_len(burst_e b);
    logic [BeatIdxW-1:0] n;
    case (b)
      BurstProbe:    n = 3'd2;
      BurstCmd:      n = 3'd7;
      BurstWordRd:   n = 3'd2;
      BurstWordDone: n = 3'd2;
      BurstNone:     n = 3'd0;
      default:       n = 3'd1;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/ata_pio_lba28_sector_reader.sv
// Top level of the ATA PIO LBA28 single-sector read sequencer.
// Depends on apsr_pkg, apsr_ctrl and apsr_emit.
//
//  Channel   Direction  Payload
//  s_axis    in         tuser: command; tdata: lba, read_data
//  m_axis    out        tuser: kind; tdata: port_offset .. drive_present; tlast
//  cfg       in         drq_poll_limit, written when cfg_we_i is high
//
// An input beat is decided in the cycle it is accepted; its results, up to seven and none
// for a stray beat, pass the descriptor register and the emitter's register and leave it
// one per cycle while m_axis is ready. A new input beat is taken every cycle while each
// causes a single result and m_axis is ready; a longer burst holds later input beats back.
// One decided burst can wait in the descriptor register while the emitter sends the
// previous one; a stalled m_axis holds both. Reset is asynchronous and needs no clearing.
module ata_pio_lba28_sector_reader (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [19:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // lba[27:0], read_data[43:28], zero pad
  input  logic [1:0]  s_axis_tuser,  // command[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // port_offset[2:0], write_value[10:3],
                                     // word_out[26:11], success[27],
                                     // drive_present[28], zero pad
  output logic [1:0]  m_axis_tuser,  // kind[1:0]
  output logic        m_axis_tlast
);
  import apsr_pkg::*;

  apsr_desc_t desc;
  logic       desc_valid;
  logic       desc_ready;
  apsr_beat_t beat;
  logic       present;

  apsr_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_cmd_i     (s_axis_tuser),
    .in_lba_i     (s_axis_tdata[27:0]),
    .in_data_i    (s_axis_tdata[43:28]),
    .desc_valid_o (desc_valid),
    .desc_o       (desc),
    .desc_ready_i (desc_ready)
  );

  apsr_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .desc_valid_i  (desc_valid),
    .desc_i        (desc),
    .desc_ready_o  (desc_ready),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .beat_o        (beat),
    .out_present_o (present),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tuser = beat.kind;
  assign m_axis_tdata = {3'b000, present, beat.success, beat.word, beat.wval, beat.port};

endmodule

>>> rtl/apsr_ctrl.sv
// Sequencer state and per-beat decision logic, with the descriptor register.
// Depends on apsr_pkg.
module apsr_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [apsr_pkg::PollW-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 in_cmd_i,
  input  logic [apsr_pkg::LbaW-1:0]  in_lba_i,
  input  logic [apsr_pkg::DataW-1:0] in_data_i,
  output logic                       desc_valid_o,
  output apsr_pkg::apsr_desc_t       desc_o,
  input  logic                       desc_ready_i
);
  import apsr_pkg::*;

  localparam logic [2:0] PhIdle  = 3'd0;
  localparam logic [2:0] PhProbe = 3'd1;
  localparam logic [2:0] PhBsy   = 3'd2;
  localparam logic [2:0] PhDrq   = 3'd3;
  localparam logic [2:0] PhData  = 3'd4;

  logic [2:0]          phase_q, phase_d;
  logic                present_q, present_d;
  logic [LbaW-1:0]     lba_q, lba_d;
  logic [PollW-1:0]    poll_q, poll_d, poll_inc;
  logic [WordCntW-1:0] word_q, word_d, word_inc;
  logic [2:0]          delay_q, delay_d;
  logic [PollW-1:0]    limit_q;
  logic                valid_q, valid_d;
  apsr_desc_t          desc_q, desc_d;
  logic                accept;
  logic [7:0]          status;
  cmd_e                cmd;

  assign in_ready_o   = !valid_q || desc_ready_i;
  assign accept       = in_valid_i && in_ready_o;
  assign status       = in_data_i[7:0];
  assign cmd          = cmd_e'(in_cmd_i);
  assign poll_inc     = poll_q + 1'b1;
  assign word_inc     = word_q + 1'b1;
  assign desc_valid_o = valid_q;
  assign desc_o       = desc_q;

  always_comb begin
    phase_d   = phase_q;
    present_d = present_q;
    lba_d     = lba_q;
    poll_d    = poll_q;
    word_d    = word_q;
    delay_d   = delay_q;
    desc_d.burst   = BurstNone;
    desc_d.lba     = lba_q;
    desc_d.word    = in_data_i;
    desc_d.success = 1'b0;
    case (cmd)
      CmdProbe: begin
        desc_d.burst = BurstProbe;
        delay_d      = '0;
        phase_d      = PhProbe;
      end
      CmdRead: begin
        if (!present_q) begin
          desc_d.burst = BurstDone;
          phase_d      = PhIdle;
        end else begin
          lba_d        = in_lba_i;
          desc_d.burst = BurstPoll;
          phase_d      = PhBsy;
        end
      end
      CmdData: begin
        case (phase_q)
          PhProbe: begin
            if (delay_q < 3'd4) begin
              delay_d      = delay_q + 1'b1;
              desc_d.burst = BurstPoll;
            end else begin
              present_d      = (status != StatFloat);
              desc_d.burst   = BurstDone;
              desc_d.success = present_d;
              phase_d        = PhIdle;
            end
          end
          PhBsy: begin
            if (status[7]) begin
              desc_d.burst = BurstPoll;
            end else begin
              desc_d.burst = BurstCmd;
              poll_d       = '0;
              phase_d      = PhDrq;
            end
          end
          PhDrq: begin
            if (status[0]) begin
              desc_d.burst = BurstDone;
              phase_d      = PhIdle;
            end else if (status[3]) begin
              word_d       = '0;
              desc_d.burst = BurstDataRd;
              phase_d      = PhData;
            end else begin
              poll_d = poll_inc;
              // A zero limit behaves like a limit of one.
              if (poll_inc >= limit_q || poll_inc == '0) begin
                desc_d.burst = BurstDone;
                phase_d      = PhIdle;
              end else begin
                desc_d.burst = BurstPoll;
              end
            end
          end
          PhData: begin
            word_d = word_inc;
            if (word_inc >= WordCntW'(SectorWords)) begin
              desc_d.burst   = BurstWordDone;
              desc_d.success = 1'b1;
              phase_d        = PhIdle;
            end else begin
              desc_d.burst = BurstWordRd;
            end
          end
          default: begin
            phase_d = PhIdle;
          end
        endcase
      end
      default: begin
        desc_d.burst = BurstNone;
      end
    endcase
    desc_d.present = present_d;
  end

  always_comb begin
    valid_d = valid_q;
    if (accept && desc_d.burst != BurstNone) begin
      valid_d = 1'b1;
    end else if (desc_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      present_q <= 1'b0;
      lba_q     <= '0;
      poll_q    <= '0;
      word_q    <= '0;
      delay_q   <= '0;
      limit_q   <= PollLimitReset;
      valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (accept) begin
        phase_q   <= phase_d;
        present_q <= present_d;
        lba_q     <= lba_d;
        poll_q    <= poll_d;
        word_q    <= word_d;
        delay_q   <= delay_d;
      end
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      desc_q <= desc_d;
    end
  end

  // A queued burst that the emitter has not taken must not change.
  a_desc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !desc_ready_i |=> valid_q && $stable(desc_q))
    else $error("descriptor changed while stalled");

  // A read request with no drive present ends in idle.
  a_nodrive_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd == CmdRead && !present_q |=> phase_q == PhIdle && !present_q)
    else $error("read without drive did not return to idle");

  // Entering the DRQ wait always restarts the poll counter.
  a_drq_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd == CmdData && phase_q == PhBsy && !status[7] |=> poll_q == '0)
    else $error("poll counter not cleared on DRQ entry");

endmodule

>>> rtl/apsr_emit.sv
// Result emitter: holds one burst descriptor and sends its beats one per cycle while out_ready_i is high.
// Depends on apsr_pkg.
module apsr_emit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 desc_valid_i,
  input  apsr_pkg::apsr_desc_t desc_i,
  output logic                 desc_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output apsr_pkg::apsr_beat_t beat_o,
  output logic                 out_present_o,
  output logic                 out_last_o
);
  import apsr_pkg::*;

  logic                valid_q;
  logic [BeatIdxW-1:0] idx_q;
  apsr_desc_t          desc_q;
  logic                take;
  logic                load;
  apsr_beat_t          beat;

  always_comb begin
    beat.kind    = KindRead;
    beat.port    = RegStatus;
    beat.wval    = '0;
    beat.word    = '0;
    beat.success = 1'b0;
    case (desc_q.burst)
      BurstProbe: begin
        if (idx_q == 3'd0) begin
          beat.kind = KindWrite;
          beat.port = RegDrive;
          beat.wval = DriveSelLba;
        end
      end
      BurstCmd: begin
        case (idx_q)
          3'd0: begin
            beat.kind = KindWrite;
            beat.port = RegDrive;
            beat.wval = DriveSelLba | {4'h0, desc_q.lba[27:24]};
          end
          3'd1: begin
            beat.kind = KindWrite;
            beat.port = RegSecCnt;
            beat.wval = 8'd1;
          end
          3'd2: begin
            beat.kind = KindWrite;
            beat.port = RegLbaLo;
            beat.wval = desc_q.lba[7:0];
          end
          3'd3: begin
            beat.kind = KindWrite;
            beat.port = RegLbaMid;
            beat.wval = desc_q.lba[15:8];
          end
          3'd4: begin
            beat.kind = KindWrite;
            beat.port = RegLbaHi;
            beat.wval = desc_q.lba[23:16];
          end
          3'd5: begin
            beat.kind = KindWrite;
            beat.port = RegStatus;
            beat.wval = CmdReadSect;
          end
          default: begin
            beat.kind = KindRead;
          end
        endcase
      end
      BurstDataRd: begin
        beat.port = RegData;
      end
      BurstDone: begin
        beat.kind    = KindDone;
        beat.port    = RegData;
        beat.success = desc_q.success;
      end
      BurstWordRd, BurstWordDone: begin
        beat.port = RegData;
        if (idx_q == 3'd0) begin
          beat.kind = KindWord;
          beat.word = desc_q.word;
        end else if (desc_q.burst == BurstWordDone) begin
          beat.kind    = KindDone;
          beat.success = desc_q.success;
        end
      end
      default: begin
        beat.kind = KindRead;
      end
    endcase
  end

  assign out_last_o    = (idx_q == burst_len(desc_q.burst) - 1'b1);
  assign take          = valid_q && out_ready_i;
  assign desc_ready_o  = !valid_q || (take && out_last_o);
  assign load          = desc_valid_i && desc_ready_o;
  assign out_valid_o   = valid_q;
  assign beat_o        = beat;
  assign out_present_o = desc_q.present;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (take) begin
      if (out_last_o) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      desc_q <= desc_i;
    end
  end

  // The beat index stays inside the burst that is being sent.
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> idx_q < burst_len(desc_q.burst))
    else $error("beat index beyond burst length");

  // A sector ends with a data word followed by a successful done.
  a_sector_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && desc_q.burst == BurstWordDone && out_last_o
      |-> beat.kind == KindDone && beat.success)
    else $error("sector did not end with a successful done");

  // A result beat that is not taken stays on the bus unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !out_ready_i |=> valid_q && $stable(beat) && $stable(out_last_o))
    else $error("result beat changed while stalled");

endmodule
